[rtl/core/lzss_pkg.sv]
// Shared types and constants for the LZSS token decompressor.
package lzss_pkg;

    localparam int BYTE_W         = 8;
    localparam int LEN_W          = 5;
    localparam int OFF_W          = 16;
    localparam int CMD_FIFO_DEPTH = 4;

    typedef enum logic [1:0] {
        PH_MARK  = 2'd0,
        PH_LIT   = 2'd1,
        PH_OFFLO = 2'd2,
        PH_OFFHI = 2'd3
    } front_phase_t;

    typedef enum logic [2:0] {
        BK_IDLE = 3'd0,
        BK_LIT  = 3'd1,
        BK_RD   = 3'd2,
        BK_WR   = 3'd3,
        BK_TAIL = 3'd4
    } back_state_t;

    typedef enum logic [1:0] {
        CMD_LIT   = 2'd0,
        CMD_COPY  = 2'd1,
        CMD_FAULT = 2'd2
    } cmd_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_OFFSET = 2'd1,
        ERR_TRUNC  = 2'd2
    } err_code_t;

    // One unit of work handed from the parser to the executor.
    typedef struct packed {
        cmd_kind_t         kind;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic [OFF_W-1:0]  off;
        err_code_t         code;   // code of the error result, if one is sent
        logic              tail;   // literal is followed by an error result
        logic              flush;  // last command of the stream
    } lzss_cmd_t;

endpackage

[rtl/core/lzss_token_decompressor.sv]
// LZSS token decompressor top level: parser, command queue and executor.
//
// Compressed bytes enter on the s_axis side, one word per byte, with tlast on
// the final byte of a stream; decompressed bytes leave on the m_axis side with
// tlast on the last result of each input byte and the error code in tuser.
// The parser takes one byte per cycle while the command queue has room; mark
// bytes and low offset bytes produce no command unless they carry tlast. The
// executor fetches a command in BK_IDLE, then emits each literal byte from
// BK_LIT and each copied match byte through BK_RD and BK_WR, since the
// registered read of the history RAM must finish before the byte is emitted
// and written back (a copy may read the byte written just before it).
// History needs no clearing pass after reset: offsets are checked against the
// number of bytes written, so no unwritten entry is ever read. After a byte
// with tlast the block returns to its reset state.
module lzss_token_decompressor #(
    parameter int WINDOW_DEPTH = 4096,
    parameter int MIN_MATCH    = 3
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // last_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,   // run_end
    output logic [1:0] m_axis_tuser    // [1:0] error_code
);
    import lzss_pkg::*;

    lzss_cmd_t front_cmd;
    logic      front_cmd_valid;
    logic      fifo_ready;
    lzss_cmd_t head_cmd;
    logic      head_valid;
    logic      head_pop;
    err_code_t out_code;

    lzss_front #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .MIN_MATCH    (MIN_MATCH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .cmd_valid (front_cmd_valid),
        .cmd_ready (fifo_ready),
        .cmd       (front_cmd)
    );

    lzss_cmd_fifo #(
        .DEPTH (CMD_FIFO_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_cmd_valid),
        .push_ready (fifo_ready),
        .push_data  (front_cmd),
        .pop_valid  (head_valid),
        .pop        (head_pop),
        .pop_data   (head_cmd)
    );

    lzss_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (head_valid),
        .cmd_pop   (head_pop),
        .cmd       (head_cmd),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_code  (out_code)
    );

    assign m_axis_tuser = 2'(out_code);

endmodule

[rtl/core/lzss_ram.sv]
// Generic single-clock RAM with one write port and a registered read port.
module lzss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/lzss_cmd_fifo.sv]
// Small command queue between the token parser and the executor.
module lzss_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  lzss_pkg::lzss_cmd_t push_data,
    output logic                pop_valid,
    input  logic                pop,
    output lzss_pkg::lzss_cmd_t pop_data
);
    import lzss_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    lzss_cmd_t     slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/core/lzss_front.sv]
// Token parser: takes compressed bytes, checks offsets, and issues commands.
module lzss_front #(
    parameter int WINDOW_DEPTH = 4096,
    parameter int MIN_MATCH    = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output lzss_pkg::lzss_cmd_t cmd
);
    import lzss_pkg::*;

    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int VW = ((CW > OFF_W) ? CW : OFF_W) + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);

    front_phase_t      phase_reg;
    front_phase_t      phase_next;
    logic [3:0]        lit_left_reg;
    logic [3:0]        lit_left_next;
    logic [LEN_W-1:0]  pend_len_reg;
    logic [LEN_W-1:0]  pend_len_next;
    logic [BYTE_W-1:0] off_lo_reg;
    logic [BYTE_W-1:0] off_lo_next;
    logic [CW-1:0]     written_reg;
    logic [CW-1:0]     written_next;

    logic              accept;
    logic [3:0]        lit_dec;
    logic [OFF_W-1:0]  off_full;
    logic              off_bad;
    logic [VW-1:0]     copy_sum;

    assign in_ready = cmd_ready;
    assign accept   = in_valid && in_ready;
    assign lit_dec  = lit_left_reg - 4'd1;
    assign off_full = {in_byte, off_lo_reg};
    // The written count never exceeds the window, so this also bounds the offset.
    assign off_bad  = (off_full == '0) || (VW'(off_full) > VW'(written_reg));
    assign copy_sum = VW'(written_reg) + VW'(pend_len_reg);

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_MARK:
                begin
                    phase_next = (in_byte[3:0] != 4'd0) ? PH_LIT : PH_OFFLO;
                end
                PH_LIT:
                begin
                    phase_next = (lit_dec == 4'd0) ? PH_MARK : PH_LIT;
                end
                PH_OFFLO:
                begin
                    phase_next = PH_OFFHI;
                end
                PH_OFFHI:
                begin
                    phase_next = PH_MARK;
                end
                default:
                begin
                    phase_next = PH_MARK;
                end
            endcase
            if (in_last)
            begin
                phase_next = PH_MARK;
            end
        end
    end

    // Commands and token registers
    always_comb
    begin
        lit_left_next  = lit_left_reg;
        pend_len_next  = pend_len_reg;
        off_lo_next    = off_lo_reg;
        written_next   = written_reg;
        cmd_valid      = 1'b0;
        cmd.kind       = CMD_FAULT;
        cmd.data       = in_byte;
        cmd.len        = pend_len_reg;
        cmd.off        = off_full;
        cmd.code       = ERR_TRUNC;
        cmd.tail       = 1'b0;
        cmd.flush      = in_last;
        if (accept)
        begin
            case (phase_reg)
                PH_MARK:
                begin
                    lit_left_next = in_byte[3:0];
                    pend_len_next = LEN_W'(in_byte[7:4]) + LEN_W'(MIN_MATCH);
                    cmd_valid     = in_last;
                end
                PH_LIT:
                begin
                    lit_left_next = lit_dec;
                    written_next  = (written_reg == DEPTH_C) ? written_reg
                                                             : written_reg + 1'b1;
                    cmd_valid     = 1'b1;
                    cmd.kind      = CMD_LIT;
                    cmd.tail      = in_last && (lit_dec != 4'd0);
                end
                PH_OFFLO:
                begin
                    off_lo_next = in_byte;
                    cmd_valid   = in_last;
                end
                PH_OFFHI:
                begin
                    cmd_valid     = 1'b1;
                    pend_len_next = '0;
                    if (off_bad)
                    begin
                        cmd.kind = CMD_FAULT;
                        cmd.code = ERR_OFFSET;
                    end
                    else
                    begin
                        cmd.kind     = CMD_COPY;
                        written_next = (copy_sum > VW'(WINDOW_DEPTH)) ? DEPTH_C
                                                                      : copy_sum[CW-1:0];
                    end
                end
                default:
                begin
                    cmd_valid = 1'b0;
                end
            endcase
            // Drop all token state at the end of the stream.
            if (in_last)
            begin
                lit_left_next = '0;
                pend_len_next = '0;
                off_lo_next   = '0;
                written_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_MARK;
            lit_left_reg <= '0;
            pend_len_reg <= '0;
            off_lo_reg   <= '0;
            written_reg  <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            lit_left_reg <= lit_left_next;
            pend_len_reg <= pend_len_next;
            off_lo_reg   <= off_lo_next;
            written_reg  <= written_next;
        end
    end

endmodule

[rtl/core/lzss_back.sv]
// Command executor: emits literals, copies matches from history, reports errors.
module lzss_back #(
    parameter int WINDOW_DEPTH = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_pop,
    input  lzss_pkg::lzss_cmd_t  cmd,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output logic                 out_last,
    output lzss_pkg::err_code_t  out_code
);
    import lzss_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int PW = $clog2(2 * WINDOW_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW_DEPTH - 1);

    back_state_t       state_reg;
    back_state_t       state_next;
    lzss_cmd_t         cmd_reg;
    lzss_cmd_t         cmd_next;
    logic [AW-1:0]     wr_idx_reg;
    logic [AW-1:0]     wr_idx_next;
    logic [AW-1:0]     rd_ptr_reg;
    logic [AW-1:0]     rd_ptr_next;
    logic [LEN_W-1:0]  cnt_reg;
    logic [LEN_W-1:0]  cnt_next;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              out_last_reg;
    err_code_t         out_code_reg;

    logic              out_free;
    logic              load;
    logic [7:0]        load_byte;
    logic              load_last;
    err_code_t         load_code;
    logic              ram_wr_en;
    logic [7:0]        ram_wr_data;
    logic              ram_rd_en;
    logic [7:0]        ram_rd_data;
    logic [AW-1:0]     wr_idx_inc;
    logic [AW-1:0]     rd_ptr_inc;
    logic [PW-1:0]     start_base;
    logic [AW-1:0]     start_ptr;

    assign out_free   = !out_valid_reg || out_ready;
    assign wr_idx_inc = (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
    assign start_base = PW'(wr_idx_reg) + PW'(WINDOW_DEPTH) - PW'(cmd.off);
    assign start_ptr  = (start_base >= PW'(WINDOW_DEPTH))
                        ? AW'(start_base - PW'(WINDOW_DEPTH)) : AW'(start_base);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        CMD_LIT:  state_next = BK_LIT;
                        CMD_COPY: state_next = BK_RD;
                        default:  state_next = BK_TAIL;
                    endcase
                end
            end
            BK_LIT:
            begin
                if (out_free)
                begin
                    state_next = cmd_reg.tail ? BK_TAIL : BK_IDLE;
                end
            end
            BK_RD:
            begin
                state_next = BK_WR;
            end
            BK_WR:
            begin
                if (out_free)
                begin
                    state_next = (cnt_reg == LEN_W'(1)) ? BK_IDLE : BK_RD;
                end
            end
            BK_TAIL:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        cmd_pop     = 1'b0;
        cmd_next    = cmd_reg;
        wr_idx_next = wr_idx_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        load        = 1'b0;
        load_byte   = '0;
        load_last   = 1'b1;
        load_code   = ERR_NONE;
        ram_wr_en   = 1'b0;
        ram_wr_data = cmd_reg.data;
        ram_rd_en   = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop     = 1'b1;
                    cmd_next    = cmd;
                    rd_ptr_next = start_ptr;
                    cnt_next    = cmd.len;
                end
            end
            BK_LIT:
            begin
                if (out_free)
                begin
                    load        = 1'b1;
                    load_byte   = cmd_reg.data;
                    load_last   = !cmd_reg.tail;
                    ram_wr_en   = 1'b1;
                    wr_idx_next = (cmd_reg.flush && !cmd_reg.tail) ? '0 : wr_idx_inc;
                end
            end
            BK_RD:
            begin
                ram_rd_en = 1'b1;
            end
            BK_WR:
            begin
                if (out_free)
                begin
                    load        = 1'b1;
                    load_byte   = ram_rd_data;
                    load_last   = (cnt_reg == LEN_W'(1));
                    ram_wr_en   = 1'b1;
                    ram_wr_data = ram_rd_data;
                    rd_ptr_next = rd_ptr_inc;
                    cnt_next    = cnt_reg - 1'b1;
                    wr_idx_next = (cmd_reg.flush && (cnt_reg == LEN_W'(1))) ? '0
                                                                            : wr_idx_inc;
                end
            end
            BK_TAIL:
            begin
                if (out_free)
                begin
                    load      = 1'b1;
                    load_code = cmd_reg.code;
                    if (cmd_reg.flush)
                    begin
                        wr_idx_next = '0;
                    end
                end
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    lzss_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_history (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_idx_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            wr_idx_reg    <= '0;
            rd_ptr_reg    <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_idx_reg    <= wr_idx_next;
            rd_ptr_reg    <= rd_ptr_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= load ? 1'b1 : (out_valid_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (load)
        begin
            out_byte_reg <= load_byte;
            out_last_reg <= load_last;
            out_code_reg <= load_code;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_code  = out_code_reg;

endmodule
